/* rtl/marching_squares_cell_segments_defines.svh */
// assertion macros shared by the marching squares checker
`ifndef MARCHING_SQUARES_CELL_SEGMENTS_DEFINES_SVH
`define MARCHING_SQUARES_CELL_SEGMENTS_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MSQ_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MSQ_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msq_pkg.sv */
// package with types, constants and the case table of the marching squares block
package msq_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_GRID_DIM    = 4096;
  localparam int GRID_DIM_W      = 13;
  localparam int INDEX_W         = 12;
  localparam int COORD_W         = 32;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [63:0] Q_ONE_RAW  = 64'h0000_0000_0001_0000;
  localparam logic [63:0] Q_HALF_RAW = 64'h0000_0000_0000_8000;

  // stream layouts
  localparam int IN_TDATA_W     = 288;
  localparam int IN_COL_LSB     = 0;
  localparam int IN_ROW_LSB     = 12;
  localparam int IN_MASK_LSB    = 24;
  localparam int IN_ISO_LSB     = 28;
  localparam int OUT_TDATA_W    = 264;
  localparam int OUT_CASE_LSB   = 0;
  localparam int OUT_COUNT_LSB  = 4;
  localparam int OUT_SEG1_LSB   = 6;
  localparam int OUT_SEG2_LSB   = 134;
  localparam int OUT_USED_MSB   = 261;

  // case codes with special meaning
  localparam logic [3:0] CASE_EMPTY    = 4'd0;
  localparam logic [3:0] CASE_FULL     = 4'd15;
  localparam logic [3:0] CASE_SADDLE_A = 4'd5;
  localparam logic [3:0] CASE_SADDLE_B = 4'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_STEP_X       = 3'd2,
    REG_STEP_Y       = 3'd3,
    REG_GRID_COLUMNS = 3'd4,
    REG_GRID_ROWS    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EDGE_BOTTOM = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  typedef struct packed {
    edge_t      start0;
    edge_t      end0;
    edge_t      start1;
    edge_t      end1;
    logic [1:0] count;
  } seg_plan_t;

  typedef struct packed {
    logic [INDEX_W-1:0]      cell_column;
    logic [INDEX_W-1:0]      cell_row;
    logic [3:0]              corner_present_mask;
    logic [3:0][COORD_W-1:0] iso_x;
    logic [3:0][COORD_W-1:0] iso_y;
  } cell_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } segment_t;

  typedef struct packed {
    logic [3:0] case_code;
    logic [1:0] segment_count;
    segment_t   first;
    segment_t   second;
  } cell_result_t;

  // segments for each case code, edges named by the cell side they cross
  function automatic seg_plan_t seg_plan(input logic [3:0] code);
    seg_plan_t p;
    p = '{EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, 2'd0};
    case (code)
      4'd1:    p = '{EDGE_LEFT,   EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd2:    p = '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd3:    p = '{EDGE_LEFT,   EDGE_RIGHT,  EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd4:    p = '{EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd5:    p = '{EDGE_TOP,    EDGE_RIGHT,  EDGE_LEFT,   EDGE_BOTTOM, 2'd2};
      4'd6:    p = '{EDGE_TOP,    EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd7:    p = '{EDGE_LEFT,   EDGE_TOP,    EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd8:    p = '{EDGE_LEFT,   EDGE_TOP,    EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd9:    p = '{EDGE_TOP,    EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd10:   p = '{EDGE_TOP,    EDGE_LEFT,   EDGE_BOTTOM, EDGE_RIGHT,  2'd2};
      4'd11:   p = '{EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd12:   p = '{EDGE_LEFT,   EDGE_RIGHT,  EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd13:   p = '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      4'd14:   p = '{EDGE_LEFT,   EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, 2'd1};
      default: p = '{EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, 2'd0};
    endcase
    return p;
  endfunction

endpackage

/* rtl/msq_cell_eval.sv */
// combinational evaluation of one cell: corner positions, case code and segments
module msq_cell_eval #(
  parameter int VALUE_WIDTH = msq_pkg::VALUE_WIDTH_DEF
) (
  input  logic [VALUE_WIDTH-1:0]          origin_x,
  input  logic [VALUE_WIDTH-1:0]          origin_y,
  input  logic [VALUE_WIDTH-1:0]          step_x,
  input  logic [VALUE_WIDTH-1:0]          step_y,
  input  logic [msq_pkg::GRID_DIM_W-1:0] grid_columns,
  input  logic [msq_pkg::GRID_DIM_W-1:0] grid_rows,
  input  msq_pkg::cell_item_t            item,
  output msq_pkg::cell_result_t          result
);
  import msq_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam logic [VW-1:0] ONE  = VW'(Q_ONE_RAW);
  localparam logic [VW-1:0] HALF = VW'(Q_HALF_RAW);

  logic [VW-1:0]   prod_x, prod_y;
  logic [VW-1:0]   px_lo, px_hi, py_lo, py_hi;
  logic [VW-1:0]   fall_x, fall_y;
  logic [VW-1:0]   ix [4];
  logic [VW-1:0]   iy [4];
  logic [VW-1:0]   cx [4];
  logic [VW-1:0]   cy [4];
  logic [3:0]      code;
  logic [VW-1:0]   nudge_x, nudge_y;
  logic            edge_cell;
  seg_plan_t       plan;

  function automatic logic [VW-1:0] pick_x(input edge_t e, input logic [VW-1:0] nx,
                                           input logic [VW-1:0] xlo, input logic [VW-1:0] xhi);
    logic [VW-1:0] v;
    case (e)
      EDGE_BOTTOM: v = nx;
      EDGE_RIGHT:  v = xhi;
      EDGE_TOP:    v = nx;
      EDGE_LEFT:   v = xlo;
      default:     v = xlo;
    endcase
    return v;
  endfunction

  function automatic logic [VW-1:0] pick_y(input edge_t e, input logic [VW-1:0] ny,
                                           input logic [VW-1:0] ylo, input logic [VW-1:0] yhi);
    logic [VW-1:0] v;
    case (e)
      EDGE_BOTTOM: v = ylo;
      EDGE_RIGHT:  v = ny;
      EDGE_TOP:    v = yhi;
      EDGE_LEFT:   v = ny;
      default:     v = ylo;
    endcase
    return v;
  endfunction

  // one multiplier per axis, the far corner is one step further
  assign prod_x = VW'(item.cell_column) * step_x;
  assign prod_y = VW'(item.cell_row) * step_y;
  assign px_lo  = origin_x + prod_x;
  assign px_hi  = px_lo + step_x;
  assign py_lo  = origin_y + prod_y;
  assign py_hi  = py_lo + step_y;
  assign fall_x = origin_x - ONE;
  assign fall_y = origin_y - ONE;

  assign edge_cell = ({1'b0, item.cell_column} + GRID_DIM_W'(1) >= grid_columns) ||
                     ({1'b0, item.cell_row} + GRID_DIM_W'(1) >= grid_rows);

  always_comb begin
    cx[0] = px_lo; cx[1] = px_hi; cx[2] = px_hi; cx[3] = px_lo;
    cy[0] = py_lo; cy[1] = py_lo; cy[2] = py_hi; cy[3] = py_hi;
    for (int i = 0; i < 4; i++) begin
      if (item.corner_present_mask[i]) begin
        ix[i] = VW'($signed(item.iso_x[i]));
        iy[i] = VW'($signed(item.iso_y[i]));
      end else begin
        ix[i] = fall_x;
        iy[i] = fall_y;
      end
      code[i] = ($signed(cx[i]) <= $signed(ix[i])) && ($signed(cy[i]) <= $signed(iy[i]));
    end
  end

  // edge points take corner 0's iso value, moved half a unit off a hit on the low corner
  assign nudge_x = (ix[0] == px_lo) ? px_lo + HALF : ix[0];
  assign nudge_y = (iy[0] == py_lo) ? py_lo + HALF : iy[0];
  assign plan    = seg_plan(code);

  always_comb begin
    result = '0;
    if (!edge_cell) begin
      result.case_code     = code;
      result.segment_count = plan.count;
      if (plan.count != 2'd0) begin
        result.first.start_x = COORD_W'(pick_x(plan.start0, nudge_x, px_lo, px_hi));
        result.first.start_y = COORD_W'(pick_y(plan.start0, nudge_y, py_lo, py_hi));
        result.first.end_x   = COORD_W'(pick_x(plan.end0, nudge_x, px_lo, px_hi));
        result.first.end_y   = COORD_W'(pick_y(plan.end0, nudge_y, py_lo, py_hi));
      end
      if (plan.count == 2'd2) begin
        result.second.start_x = COORD_W'(pick_x(plan.start1, nudge_x, px_lo, px_hi));
        result.second.start_y = COORD_W'(pick_y(plan.start1, nudge_y, py_lo, py_hi));
        result.second.end_x   = COORD_W'(pick_x(plan.end1, nudge_x, px_lo, px_hi));
        result.second.end_y   = COORD_W'(pick_y(plan.end1, nudge_y, py_lo, py_hi));
      end
    end
  end

endmodule

/* rtl/marching_squares_cell_segments.sv */
// top level of the marching squares cell segment generator
// One grid cell in per beat, one result beat out per cell, at a sustained rate of one cell
// per clock while out_tready holds, through an input register, then a result register. The cell's
// corner positions are origin plus index times step (one multiplier per axis), each corner is
// set when its position is at or below its iso pair, and the 4-bit case code selects zero,
// one or two segments whose end points sit on the cell sides. Cells in the last column or
// row give an all-zero result. All arithmetic is two's complement Q16.16 that wraps. The
// evaluation sits between the two registers, so that path (multiply, add, compare, select)
// sets the clock. Configuration writes are taken in any cycle and must only be issued while
// no cell is in flight; indexes beyond the register list are dropped.
module marching_squares_cell_segments #(
  parameter int VALUE_WIDTH = msq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [msq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [msq_pkg::CFG_DATA_W-1:0]  cfg_data,
  // cell stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cell_column, cell_row, corner_present_mask, iso_x_corner0, iso_y_corner0,
  // iso_x_corner1, iso_y_corner1, iso_x_corner2, iso_y_corner2, iso_x_corner3,
  // iso_y_corner3, zero pad
  input  logic [msq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // case_code, segment_count, first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y, zero pad
  output logic [msq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import msq_pkg::*;

  localparam int VW = VALUE_WIDTH;

  // configuration registers
  logic [VW-1:0]         origin_x_r, origin_y_r, step_x_r, step_y_r;
  logic [GRID_DIM_W-1:0] grid_columns_r, grid_rows_r;
  logic [VW-1:0]         cfg_value;

  // pipeline registers
  logic                  in_valid_r, in_valid_nxt;
  cell_item_t            item_r, item_nxt;
  logic                  out_valid_r, out_valid_nxt;
  cell_result_t          result_r;
  cell_result_t          result_nxt;
  logic                  in_take, res_load;

  // register writes, always ready
  assign cfg_ready = 1'b1;
  assign cfg_value = VW'($signed(cfg_data));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      step_x_r       <= VW'(Q_ONE_RAW);
      step_y_r       <= VW'(Q_ONE_RAW);
      grid_columns_r <= GRID_DIM_W'(MAX_GRID_DIM);
      grid_rows_r    <= GRID_DIM_W'(MAX_GRID_DIM);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:     origin_x_r     <= cfg_value;
        REG_ORIGIN_Y:     origin_y_r     <= cfg_value;
        REG_STEP_X:       step_x_r       <= cfg_value;
        REG_STEP_Y:       step_y_r       <= cfg_value;
        REG_GRID_COLUMNS: grid_columns_r <= cfg_data[GRID_DIM_W-1:0];
        REG_GRID_ROWS:    grid_rows_r    <= cfg_data[GRID_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the result register loads from a full input register whenever it is empty
  // or being drained, and the input register refills whenever it is empty or hands its cell on
  assign res_load  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || res_load;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (res_load) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // unpack the input beat
  always_comb begin
    item_nxt.cell_column         = in_tdata[IN_COL_LSB +: INDEX_W];
    item_nxt.cell_row            = in_tdata[IN_ROW_LSB +: INDEX_W];
    item_nxt.corner_present_mask = in_tdata[IN_MASK_LSB +: 4];
    for (int i = 0; i < 4; i++) begin
      item_nxt.iso_x[i] = in_tdata[IN_ISO_LSB + 2 * i * COORD_W +: COORD_W];
      item_nxt.iso_y[i] = in_tdata[IN_ISO_LSB + (2 * i + 1) * COORD_W +: COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
    if (res_load) begin
      result_r <= result_nxt;
    end
  end

  msq_cell_eval #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_eval (
    .origin_x     (origin_x_r),
    .origin_y     (origin_y_r),
    .step_x       (step_x_r),
    .step_y       (step_y_r),
    .grid_columns (grid_columns_r),
    .grid_rows    (grid_rows_r),
    .item         (item_r),
    .result       (result_nxt)
  );

  // pack the result beat
  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_CASE_LSB +: 4]                 = result_r.case_code;
    out_tdata[OUT_COUNT_LSB +: 2]                = result_r.segment_count;
    out_tdata[OUT_SEG1_LSB +: COORD_W]           = result_r.first.start_x;
    out_tdata[OUT_SEG1_LSB + COORD_W +: COORD_W] = result_r.first.start_y;
    out_tdata[OUT_SEG1_LSB + 2 * COORD_W +: COORD_W] = result_r.first.end_x;
    out_tdata[OUT_SEG1_LSB + 3 * COORD_W +: COORD_W] = result_r.first.end_y;
    out_tdata[OUT_SEG2_LSB +: COORD_W]           = result_r.second.start_x;
    out_tdata[OUT_SEG2_LSB + COORD_W +: COORD_W] = result_r.second.start_y;
    out_tdata[OUT_SEG2_LSB + 2 * COORD_W +: COORD_W] = result_r.second.end_x;
    out_tdata[OUT_SEG2_LSB + 3 * COORD_W +: COORD_W] = result_r.second.end_y;
  end

endmodule

/* rtl/msq_checker.sv */
// port-level checks on the result stream of the marching squares block
`include "marching_squares_cell_segments_defines.svh"

module msq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [msq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import msq_pkg::*;

  logic [3:0] case_code;
  logic [1:0] seg_count;

  assign case_code = out_tdata[OUT_CASE_LSB +: 4];
  assign seg_count = out_tdata[OUT_COUNT_LSB +: 2];

  // a stalled result beat stays put
  `MSQ_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // two segments only for the saddle codes
  `MSQ_ASSERT_NOW(a_saddle, out_tvalid && seg_count == 2'd2, case_code == CASE_SADDLE_A || case_code == CASE_SADDLE_B, "two segments outside a saddle case")

  // empty and full cells carry no segment and no coordinates
  `MSQ_ASSERT_NOW(a_flat, out_tvalid && (case_code == CASE_EMPTY || case_code == CASE_FULL), out_tdata[OUT_USED_MSB:OUT_COUNT_LSB] == '0, "flat cell has segment data")

  // fields of an uncounted second segment are zero, and the count never reaches three
  `MSQ_ASSERT_NOW(a_unused, out_tvalid && seg_count != 2'd2, seg_count != 2'd3 && out_tdata[OUT_USED_MSB:OUT_SEG2_LSB] == '0, "unused second segment not cleared")

endmodule

bind marching_squares_cell_segments msq_checker u_msq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
